### hdl/signed_integer_to_radix_digits_core_macros.svh
// Assertion macros shared by the radix digit converter modules.
// Included by each module that checks its own logic; depends on nothing.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sird_pkg.sv
// Shared constants, register indexes and controller/datapath structs.
// Used by every module of the radix digit converter; depends on nothing.
`timescale 1ns / 1ps

package sird_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 5;
    localparam int ALPHA_W     = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_WIDTH / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_LO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_HI = 2'd2;

    typedef struct packed {
        logic load;
        logic store_zero;
        logic div_start;
        logic store_digit;
        logic emit_minus;
        logic emit_digit;
    } sird_cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic count_zero;
        logic count_full;
        logic count_one;
        logic negative;
        logic div_done;
        logic out_free;
    } sird_sts_t;

endpackage

### hdl/signed_integer_to_radix_digits_core.sv
// Top level of the signed integer to radix digit string converter.
// Depends on sird_pkg, sird_ctrl, sird_datapath and sird_divider.
//
// Channel   Direction  Word contents (lowest bit first)
// s_        in         tdata: value (32 bits, signed)
// m_        out        tdata: character (8 bits); tlast: last
// cfg_      in         cfg_index: register index; cfg_data: register value
//
// For each digit the controller starts the divider, waits while it retires eight
// quotient bits a cycle, then stores the remainder as the digit. The digits are
// emitted most significant first, after the minus sign, which is written to the
// output word in the sign state.
// Reset is synchronous and active low; the radix returns to ten. A stalled
// output word holds the controller, and a new value is taken only when idle.
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sird_pkg::VALUE_WIDTH-1:0]     s_tdata,   // [31:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sird_pkg::CHAR_W-1:0]          m_tdata,   // [7:0] character
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sird_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sird_pkg::ALPHA_W-1:0]         cfg_data
);

    sird_pkg::sird_cmd_t cmd;
    sird_pkg::sird_sts_t sts;

    assign cfg_ready = 1'b1;

    sird_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sird_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (s_tdata),
        .m_ready   (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_tvalid),
        .m_char    (m_tdata),
        .m_last    (m_tlast)
    );

endmodule

### hdl/sird_divider.sv
// Iterative divider of the magnitude by the radix, eight quotient bits a cycle.
// Uses constants from sird_pkg; instantiated by the datapath.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_core_macros.svh"

module sird_divider (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [sird_pkg::VALUE_WIDTH-1:0]     dividend,
    input  logic [sird_pkg::RADIX_W-1:0]         divisor,
    output logic                                 done,
    output logic [sird_pkg::VALUE_WIDTH-1:0]     quotient,
    output logic [sird_pkg::DIGIT_W-1:0]         remainder
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [sird_pkg::DIV_STEP_W-1:0]     step_reg, step_next;
    logic [sird_pkg::VALUE_WIDTH-1:0]    work_reg, work_next;
    logic [sird_pkg::DIGIT_W-1:0]        rem_reg, rem_next;
    logic [sird_pkg::RADIX_W-1:0]        base_reg, base_next;

    logic [sird_pkg::VALUE_WIDTH-1:0]    w_c;
    logic [sird_pkg::DIGIT_W-1:0]        r_c;
    logic [sird_pkg::RADIX_W-1:0]        t_c;
    logic [sird_pkg::RADIX_W-1:0]        d_c;

    always_comb begin
        w_c = work_reg;
        r_c = rem_reg;
        t_c = '0;
        d_c = '0;
        for (int i = 0; i < sird_pkg::DIV_BITS; i++) begin
            t_c = {r_c, w_c[sird_pkg::VALUE_WIDTH-1]};
            w_c = {w_c[sird_pkg::VALUE_WIDTH-2:0], 1'b0};
            if (t_c >= base_reg) begin
                d_c    = t_c - base_reg;
                r_c    = d_c[sird_pkg::DIGIT_W-1:0];
                w_c[0] = 1'b1;
            end else begin
                r_c = t_c[sird_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            work_next = dividend;
            rem_next  = '0;
            base_next = divisor;
        end else if (busy_reg) begin
            work_next = w_c;
            rem_next  = r_c;
            step_next = step_reg + 1'b1;
            if (step_reg == sird_pkg::DIV_STEP_W'(sird_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

    `SIRD_ASSERT_SAME(a_rem_below_base, aclk, aresetn, done_reg, {1'b0, rem_reg} < base_reg, "remainder not below radix")
    `SIRD_ASSERT_SAME(a_start_when_free, aclk, aresetn, start, !busy_reg, "divider restarted while busy")

endmodule

### hdl/sird_datapath.sv
// Datapath: configuration registers, magnitude, digit store, output word register.
// Uses sird_pkg and instantiates sird_divider; driven by sird_ctrl commands.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_core_macros.svh"

module sird_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_write,
    input  logic [sird_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sird_pkg::ALPHA_W-1:0]          cfg_data,
    input  logic [sird_pkg::VALUE_WIDTH-1:0]      value,
    input  logic                                  m_ready,
    input  sird_pkg::sird_cmd_t                   cmd,
    output sird_pkg::sird_sts_t                   sts,
    output logic                                  m_valid,
    output logic [sird_pkg::CHAR_W-1:0]           m_char,
    output logic                                  m_last
);

    logic [sird_pkg::RADIX_W-1:0]      radix_reg, radix_next;
    logic [sird_pkg::ALPHA_W-1:0]      chars_lo_reg, chars_lo_next;
    logic [sird_pkg::ALPHA_W-1:0]      chars_hi_reg, chars_hi_next;
    logic [sird_pkg::VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic                              neg_reg, neg_next;
    logic [sird_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [sird_pkg::DIGIT_W-1:0]      digit_reg [sird_pkg::MAX_DIGITS];
    logic                              out_valid_reg, out_valid_next;
    logic [sird_pkg::CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                              out_last_reg, out_last_next;

    logic [sird_pkg::RADIX_W-1:0]      base;
    logic [sird_pkg::COUNT_W-1:0]      count_dec;
    logic [sird_pkg::DIGIT_W-1:0]      emit_digit;
    logic [2*sird_pkg::ALPHA_W-1:0]    alphabet;
    logic [sird_pkg::CHAR_W-1:0]       digit_char;
    logic                              out_free;
    logic                              div_done;
    logic [sird_pkg::VALUE_WIDTH-1:0]  div_quot;
    logic [sird_pkg::DIGIT_W-1:0]      div_rem;

    always_comb begin
        if (radix_reg inside {[5'd0:5'd1]}) begin
            base = sird_pkg::RADIX_MIN;
        end else if (radix_reg > sird_pkg::RADIX_MAX) begin
            base = sird_pkg::RADIX_MAX;
        end else begin
            base = radix_reg;
        end
    end

    sird_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag_reg),
        .divisor   (base),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign count_dec  = count_reg - sird_pkg::COUNT_W'(1);
    assign emit_digit = digit_reg[count_dec[sird_pkg::IDX_W-1:0]];
    assign alphabet   = {chars_hi_reg, chars_lo_reg};
    assign digit_char = alphabet[{emit_digit, 3'b000} +: sird_pkg::CHAR_W];
    assign out_free   = !out_valid_reg || m_ready;

    always_comb begin
        radix_next    = radix_reg;
        chars_lo_next = chars_lo_reg;
        chars_hi_next = chars_hi_reg;
        if (cfg_write) begin
            case (cfg_index)
                sird_pkg::REG_RADIX:    radix_next    = cfg_data[sird_pkg::RADIX_W-1:0];
                sird_pkg::REG_CHARS_LO: chars_lo_next = cfg_data;
                sird_pkg::REG_CHARS_HI: chars_hi_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        if (cmd.load) begin
            neg_next   = value[sird_pkg::VALUE_WIDTH-1];
            mag_next   = value[sird_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            count_next = '0;
        end else if (cmd.store_zero) begin
            count_next = sird_pkg::COUNT_W'(1);
        end else if (cmd.store_digit) begin
            mag_next   = div_quot;
            count_next = count_reg + 1'b1;
        end else if (cmd.emit_digit) begin
            count_next = count_dec;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_minus) begin
            out_valid_next = 1'b1;
            out_char_next  = sird_pkg::MINUS_CHAR;
            out_last_next  = 1'b0;
        end else if (cmd.emit_digit) begin
            out_valid_next = 1'b1;
            out_char_next  = digit_char;
            out_last_next  = (count_reg == sird_pkg::COUNT_W'(1));
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= sird_pkg::RADIX_RESET;
            chars_lo_reg  <= '0;
            chars_hi_reg  <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            radix_reg     <= radix_next;
            chars_lo_reg  <= chars_lo_next;
            chars_hi_reg  <= chars_hi_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_zero) begin
            digit_reg[0] <= '0;
        end else if (cmd.store_digit) begin
            digit_reg[count_reg[sird_pkg::IDX_W-1:0]] <= div_rem;
        end
    end

    always_comb begin
        sts            = '0;
        sts.mag_zero   = (mag_reg == '0);
        sts.count_zero = (count_reg == '0);
        sts.count_full = (count_reg == sird_pkg::COUNT_W'(sird_pkg::MAX_DIGITS));
        sts.count_one  = (count_reg == sird_pkg::COUNT_W'(1));
        sts.negative   = neg_reg;
        sts.div_done   = div_done;
        sts.out_free   = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_char  = out_char_reg;
    assign m_last  = out_last_reg;

    `SIRD_ASSERT_SAME(a_no_overrun, aclk, aresetn, cmd.emit_minus || cmd.emit_digit, out_free, "output word overwritten before it was taken")
    `SIRD_ASSERT_NEXT(a_last_flag, aclk, aresetn, cmd.emit_digit && count_reg == sird_pkg::COUNT_W'(1), out_valid_reg && out_last_reg, "final digit not flagged")

endmodule

### hdl/sird_ctrl.sv
// Controller state machine: sequences load, divisions, sign and digit output.
// Uses sird_pkg command and status structs; drives sird_datapath.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_core_macros.svh"

module sird_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sird_pkg::sird_sts_t   sts,
    output sird_pkg::sird_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.mag_zero && sts.count_zero) begin
                    cmd.store_zero = 1'b1;
                    state_next     = ST_SIGN;
                end else if (sts.mag_zero || sts.count_full) begin
                    state_next = ST_SIGN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    cmd.store_digit = 1'b1;
                    state_next      = ST_START;
                end
            end
            ST_SIGN: begin
                if (!sts.negative) begin
                    state_next = ST_EMIT;
                end else if (sts.out_free) begin
                    cmd.emit_minus = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.count_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SIRD_ASSERT_SAME(a_emit_has_digit, aclk, aresetn, state_reg == ST_EMIT, !sts.count_zero, "digit output with no digit stored")

endmodule
